[design/srtf_scheduler_top_macros.svh]
// ----------------------------------------------------------------------------
// SRTF scheduler assertion macros
// Concurrent check helpers sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SRTF_SCHEDULER_TOP_MACROS_SVH
`define SRTF_SCHEDULER_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define SRTF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define SRTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/srtf_pkg.sv]
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Shared sizes, request and response types, scan interface and state codes.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_FW   = 3;
  localparam int BURST_W   = 16;
  localparam int TICK_W    = 32;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SLOT_FW-1:0] slot_t;
  typedef logic [BURST_W-1:0] burst_t;
  typedef logic [TICK_W-1:0]  tick_t;

  typedef struct packed {
    logic   new_valid;
    slot_t  new_slot;
    burst_t new_burst;
  } req_t;

  typedef struct packed {
    logic  run_valid;
    slot_t run_slot;
    tick_t run_tick;
    logic  finished;
    logic  arrival_rejected;
  } rsp_t;

  // Control from the sequencer to the minimum tracker
  typedef struct packed {
    logic clear;
    logic sample;
    idx_t idx;
  } scan_ctrl_t;

  // Best candidate seen so far
  typedef struct packed {
    logic   found;
    idx_t   idx;
    burst_t value;
  } scan_res_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ARR   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  function automatic idx_t slot_to_idx(slot_t slot);
    return IDX_W'(slot);
  endfunction

  function automatic slot_t idx_to_slot(idx_t idx);
    return SLOT_FW'(idx);
  endfunction

  function automatic logic slot_in_range(slot_t slot);
    return int'(slot) < NUM_SLOTS;
  endfunction

endpackage

[design/srtf_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/srtf_scan.sv]
// ----------------------------------------------------------------------------
// SRTF minimum tracker
// Keeps the slot with the least nonzero remaining time over one scan pass.
// ----------------------------------------------------------------------------
module srtf_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  srtf_pkg::scan_ctrl_t   ctrl,
  input  srtf_pkg::burst_t       value,
  output srtf_pkg::scan_res_t    res
);

  logic better;

  // Strictly less keeps the lowest slot on a tie, since slots arrive in order
  assign better = (value != '0) && (!res.found || (value < res.value));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      res.found <= 1'b0;
    end else if (ctrl.sample && better) begin
      res.found <= 1'b1;
    end
    if (ctrl.sample && better) begin
      res.idx   <= ctrl.idx;
      res.value <= value;
    end
  end

endmodule

[design/srtf_scheduler_top.sv]
// ----------------------------------------------------------------------------
// SRTF scheduler top level
// Each request is one scheduling tick with an optional process arrival.
// ----------------------------------------------------------------------------
// Every request passes through the states in order when the response side is
// not stalled: accept and read the arrival slot, check and load the arrival,
// stream each slot's remaining time out of the single-read-port slot memory
// into the minimum tracker, and write the chosen slot back and register the
// response. A stalled response holds the write-back cycle until the response
// register frees up. A new request is taken while the previous response still
// waits to be collected. Slot contents are qualified by per-slot loaded bits,
// so no clearing pass follows reset.
`include "srtf_scheduler_top_macros.svh"

module srtf_scheduler_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  srtf_pkg::req_t  in_req,
  output logic            out_valid,
  input  logic            out_stall,
  output srtf_pkg::rsp_t  out_rsp
);

  srtf_pkg::state_t    state, state_next;
  srtf_pkg::req_t      req;
  srtf_pkg::cnt_t      cnt;
  srtf_pkg::tick_t     tick_count;
  logic [srtf_pkg::NUM_SLOTS-1:0] loaded;

  logic                rd_vld;
  srtf_pkg::idx_t      rd_idx;
  logic                rd_loaded;
  srtf_pkg::burst_t    rd_value;
  srtf_pkg::burst_t    ram_rdata;
  srtf_pkg::idx_t      ram_raddr;
  srtf_pkg::idx_t      ram_waddr;
  srtf_pkg::burst_t    ram_wdata;
  logic                ram_we;

  logic                arr_reject_now;
  logic                arr_reject;
  logic                out_free;
  logic                out_load;
  logic                scan_last;

  srtf_pkg::scan_ctrl_t scan_ctrl;
  srtf_pkg::scan_res_t  scan_res;

  // Slot memory holding remaining time
  srtf_ram #(
    .WIDTH (srtf_pkg::BURST_W),
    .DEPTH (srtf_pkg::NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Minimum tracker fed by the scan stream
  srtf_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (scan_ctrl),
    .value (rd_value),
    .res   (scan_res)
  );

  assign in_stall  = (state != srtf_pkg::ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == srtf_pkg::ST_WRITE) && out_free;
  assign scan_last = (cnt == srtf_pkg::CNT_W'(srtf_pkg::NUM_SLOTS));

  // Treat never-written slots as empty
  assign rd_value = rd_loaded ? ram_rdata : '0;

  // Refuse arrivals into busy or absent slots and zero bursts
  assign arr_reject_now = req.new_valid &&
                          (!srtf_pkg::slot_in_range(req.new_slot) ||
                           (req.new_burst == '0) || (rd_value != '0));

  assign scan_ctrl.clear  = (state == srtf_pkg::ST_ARR);
  assign scan_ctrl.sample = rd_vld;
  assign scan_ctrl.idx    = rd_idx;

  // Select the read address
  always_comb begin
    unique case (state)
      srtf_pkg::ST_IDLE: ram_raddr = srtf_pkg::slot_to_idx(in_req.new_slot);
      srtf_pkg::ST_SCAN: ram_raddr = cnt[srtf_pkg::IDX_W-1:0];
      default:           ram_raddr = '0;
    endcase
  end

  // Load the arrival or write back the chosen slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_res.idx;
    ram_wdata = scan_res.value - srtf_pkg::BURST_W'(1);
    unique case (state)
      srtf_pkg::ST_ARR: begin
        ram_we    = req.new_valid && !arr_reject_now;
        ram_waddr = srtf_pkg::slot_to_idx(req.new_slot);
        ram_wdata = req.new_burst;
      end
      srtf_pkg::ST_WRITE: begin
        ram_we = out_free && scan_res.found;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequence one tick
  always_comb begin
    state_next = state;
    unique case (state)
      srtf_pkg::ST_IDLE:  if (in_valid) state_next = srtf_pkg::ST_ARR;
      srtf_pkg::ST_ARR:   state_next = srtf_pkg::ST_SCAN;
      srtf_pkg::ST_SCAN:  if (scan_last) state_next = srtf_pkg::ST_WRITE;
      srtf_pkg::ST_WRITE: if (out_free) state_next = srtf_pkg::ST_IDLE;
      default:            state_next = srtf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srtf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request and track the scan
  always_ff @(posedge clk) begin
    if ((state == srtf_pkg::ST_IDLE) && in_valid) begin
      req <= in_req;
    end
    if (state == srtf_pkg::ST_ARR) begin
      arr_reject <= arr_reject_now;
      cnt        <= '0;
    end else if (state == srtf_pkg::ST_SCAN) begin
      cnt <= cnt + srtf_pkg::CNT_W'(1);
    end
    rd_idx    <= cnt[srtf_pkg::IDX_W-1:0];
    rd_loaded <= loaded[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == srtf_pkg::ST_SCAN) && !scan_last;
    end
  end

  // Mark slots as written
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (ram_we) begin
      loaded[ram_waddr] <= 1'b1;
    end
  end

  // Advance the tick counter once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (out_load) begin
      tick_count <= tick_count + srtf_pkg::TICK_W'(1);
    end
  end

  // Hold the response until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rsp.run_valid        <= scan_res.found;
      out_rsp.run_slot         <= scan_res.found ? srtf_pkg::idx_to_slot(scan_res.idx) : '0;
      out_rsp.run_tick         <= tick_count;
      out_rsp.finished         <= scan_res.found &&
                                  (scan_res.value == srtf_pkg::BURST_W'(1));
      out_rsp.arrival_rejected <= arr_reject;
    end
  end

  // Write-back always lands a response and returns to idle
  `SRTF_ASSERT_NEXT(a_write_done, out_load, (state == srtf_pkg::ST_IDLE) && out_valid, "write-back did not complete")
  // A refused arrival never touches the slot memory
  `SRTF_ASSERT_SAME(a_reject_no_write, (state == srtf_pkg::ST_ARR) && arr_reject_now, !ram_we, "refused arrival written")
  // The tracked candidate always has work left
  `SRTF_ASSERT_SAME(a_best_nonzero, scan_res.found, scan_res.value != '0, "empty slot chosen")

endmodule
